// ----- rtl/pid_pkg.sv -----
// ----------------------------------------------------------------------------
// pid_pkg: shared types and constants for the pid controller
// Widths, register indexes, mode codes and the control structs.
// ----------------------------------------------------------------------------
package pid_pkg;

  localparam int DATA_W     = 16;
  localparam int FRAC_W     = 12;
  localparam int GAIN_W     = 16;
  localparam int ILIM_W     = 16;
  localparam int LIMIT_W    = 31;
  localparam int OUT_W      = LIMIT_W + 1;
  localparam int ERR_W      = DATA_W + 1;
  localparam int OP_W       = ERR_W + 2;
  localparam int PROD_W     = GAIN_W + 1 + OP_W;
  localparam int ACC_W      = OUT_W + FRAC_W + 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [ILIM_W-1:0]  ILIM_RESET  = ILIM_W'(4000);
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = {LIMIT_W{1'b1}};
  localparam longint FRAC_ONE = longint'(1) << FRAC_W;
  localparam longint RAW_MAX  = (longint'(1) << (OUT_W - 1)) - 1;

  localparam logic [CFG_IDX_W-1:0] REG_KP       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KI       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KD       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MODE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ILIMIT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OUTLIMIT = 3'd5;

  localparam logic MODE_POS = 1'b0;
  localparam logic MODE_INC = 1'b1;

  typedef struct packed {
    logic [GAIN_W-1:0]  kp;
    logic [GAIN_W-1:0]  ki;
    logic [GAIN_W-1:0]  kd;
    logic               mode;
    logic [ILIM_W-1:0]  integral_limit;
    logic [LIMIT_W-1:0] out_limit;
  } cfg_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] raw_drive;
    logic signed [OUT_W-1:0] drive;
  } result_t;

endpackage

// ----- rtl/pid_cfg.sv -----
// ----------------------------------------------------------------------------
// pid_cfg: configuration register file
// Holds gains, mode and limits; written through the cfg channel.
// ----------------------------------------------------------------------------
module pid_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             wr_en,
  input  logic [pid_pkg::CFG_IDX_W-1:0]    wr_index,
  input  logic [pid_pkg::CFG_DATA_W-1:0]   wr_data,
  output pid_pkg::cfg_t                    cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.kp             <= '0;
      cfg.ki             <= '0;
      cfg.kd             <= '0;
      cfg.mode           <= pid_pkg::MODE_POS;
      cfg.integral_limit <= pid_pkg::ILIM_RESET;
      cfg.out_limit      <= pid_pkg::LIMIT_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        pid_pkg::REG_KP:       cfg.kp <= wr_data[pid_pkg::GAIN_W-1:0];
        pid_pkg::REG_KI:       cfg.ki <= wr_data[pid_pkg::GAIN_W-1:0];
        pid_pkg::REG_KD:       cfg.kd <= wr_data[pid_pkg::GAIN_W-1:0];
        pid_pkg::REG_MODE:     cfg.mode <= wr_data[0];
        pid_pkg::REG_ILIMIT:   cfg.integral_limit <= wr_data[pid_pkg::ILIM_W-1:0];
        pid_pkg::REG_OUTLIMIT: cfg.out_limit <= wr_data[pid_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/pid_core.sv -----
// ----------------------------------------------------------------------------
// pid_core: one pid step with in-place state update
// Forms the error, the three gain products and the new accumulator, and
// updates error sum, error history and accumulator when a step is taken.
// ----------------------------------------------------------------------------
module pid_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              step,
  input  pid_pkg::cfg_t                     cfg,
  input  logic signed [pid_pkg::DATA_W-1:0] target,
  input  logic signed [pid_pkg::DATA_W-1:0] measured,
  input  logic                              clear_state,
  output pid_pkg::result_t                  res
);

  localparam int ERR_W  = pid_pkg::ERR_W;
  localparam int OP_W   = pid_pkg::OP_W;
  localparam int PROD_W = pid_pkg::PROD_W;
  localparam int ACC_W  = pid_pkg::ACC_W;
  localparam int OUT_W  = pid_pkg::OUT_W;
  localparam int FRAC_W = pid_pkg::FRAC_W;

  logic signed [ERR_W-1:0]    error_sum, last_error, prev_error;
  logic signed [ACC_W-1:0]    output_accum;

  logic signed [ERR_W-1:0]    sum_cur, last_cur, prev_cur, err, sum_new;
  logic signed [ERR_W:0]      sum_wide, ilim;
  logic signed [OP_W-1:0]     d1, d2, op_p, op_i, op_d;
  logic signed [pid_pkg::GAIN_W:0] kp_s, ki_s, kd_s;
  logic signed [PROD_W-1:0]   prod_p, prod_i, prod_d;
  logic signed [ACC_W-1:0]    acc_cur, acc_base, acc_new, rnd, adj, q_full;
  logic signed [ACC_W-1:0]    raw_max, raw_min, lim_fx, lim_neg, acc_lim;
  logic signed [OUT_W-1:0]    lim_out;
  logic                       over, under;

  always_comb begin
    sum_cur  = clear_state ? '0 : error_sum;
    last_cur = clear_state ? '0 : last_error;
    prev_cur = clear_state ? '0 : prev_error;
    acc_cur  = clear_state ? '0 : output_accum;

    err = ERR_W'(target) - ERR_W'(measured);

    // integral with symmetric clamp
    sum_wide = (ERR_W+1)'(sum_cur) + (ERR_W+1)'(err);
    ilim     = $signed((ERR_W+1)'(cfg.integral_limit));
    if (sum_wide > ilim) begin
      sum_new = ERR_W'(ilim);
    end else if (sum_wide < -ilim) begin
      sum_new = ERR_W'(-ilim);
    end else begin
      sum_new = ERR_W'(sum_wide);
    end

    d1 = OP_W'(err) - OP_W'(last_cur);
    d2 = OP_W'(err) - (OP_W'(last_cur) <<< 1) + OP_W'(prev_cur);

    op_p = (cfg.mode == pid_pkg::MODE_INC) ? d1 : OP_W'(err);
    op_i = (cfg.mode == pid_pkg::MODE_INC) ? OP_W'(err) : OP_W'(sum_new);
    op_d = (cfg.mode == pid_pkg::MODE_INC) ? d2 : d1;

    kp_s = $signed({1'b0, cfg.kp});
    ki_s = $signed({1'b0, cfg.ki});
    kd_s = $signed({1'b0, cfg.kd});

    prod_p = kp_s * op_p;
    prod_i = ki_s * op_i;
    prod_d = kd_s * op_d;

    acc_base = (cfg.mode == pid_pkg::MODE_INC) ? acc_cur : '0;
    acc_new  = acc_base + ACC_W'(prod_p) + ACC_W'(prod_i) + ACC_W'(prod_d);

    // divide by the fraction scale, rounding toward zero
    rnd    = acc_new[ACC_W-1] ? ACC_W'(pid_pkg::FRAC_ONE - 1) : '0;
    adj    = acc_new + rnd;
    q_full = adj >>> FRAC_W;

    raw_max = ACC_W'(pid_pkg::RAW_MAX);
    raw_min = -raw_max;
    if (q_full > raw_max) begin
      res.raw_drive = raw_max[OUT_W-1:0];
    end else if (q_full < raw_min) begin
      res.raw_drive = raw_min[OUT_W-1:0];
    end else begin
      res.raw_drive = q_full[OUT_W-1:0];
    end

    // output clamp on the accumulator
    lim_fx  = $signed(ACC_W'({cfg.out_limit, FRAC_W'(0)}));
    lim_neg = -lim_fx;
    lim_out = $signed({1'b0, cfg.out_limit});
    over    = acc_new > lim_fx;
    under   = acc_new < lim_neg;
    if (over) begin
      acc_lim   = lim_fx;
      res.drive = lim_out;
    end else if (under) begin
      acc_lim   = lim_neg;
      res.drive = -lim_out;
    end else begin
      acc_lim   = acc_new;
      res.drive = q_full[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      error_sum    <= '0;
      last_error   <= '0;
      prev_error   <= '0;
      output_accum <= '0;
    end else if (step) begin
      error_sum    <= (cfg.mode == pid_pkg::MODE_INC) ? sum_cur : sum_new;
      prev_error   <= (cfg.mode == pid_pkg::MODE_INC) ? last_cur : prev_cur;
      last_error   <= err;
      output_accum <= acc_lim;
    end
  end

endmodule

// ----- rtl/pid_controller_pos_incr.sv -----
// ----------------------------------------------------------------------------
// pid_controller_pos_incr: fixed-point pid step, positional or incremental
// Input channel (in_valid/in_stall) carries target, measured and
// clear_state; output channel (out_valid/out_stall) returns raw_drive and
// drive, one result per input transaction, in order.
// A transaction is registered at the input, computed in a single pass
// through the error, gain multipliers and clamps, and lands in the output
// register.
// Throughput is one transaction per cycle while out_stall is low; controller
// state is updated in place as each transaction leaves the input register.
// When out_stall is high the output holds and the input register still
// takes one more transaction; in_stall rises only when both are full.
// cfg channel writes gains, mode and limits (cfg_ready is always high);
// write only while no transaction is in flight.
// Reset clears both pipeline valid bits, the error sum, the error history
// and the accumulator, and returns the cfg registers to their reset values.
// ----------------------------------------------------------------------------
module pid_controller_pos_incr (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [pid_pkg::DATA_W-1:0] target,
  input  logic signed [pid_pkg::DATA_W-1:0] measured,
  input  logic                              clear_state,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [pid_pkg::OUT_W-1:0]  raw_drive,
  output logic signed [pid_pkg::OUT_W-1:0]  drive,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pid_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pid_pkg::CFG_DATA_W-1:0]    cfg_data
);

  pid_pkg::cfg_t                     cfg;
  pid_pkg::result_t                  res;
  logic                              s1_valid;
  logic signed [pid_pkg::DATA_W-1:0] s1_target, s1_measured;
  logic                              s1_clear;
  logic                              advance;
  logic                              step;

  assign cfg_ready = 1'b1;
  assign advance   = !out_valid || !out_stall;
  assign in_stall  = s1_valid && !advance;
  assign step      = s1_valid && advance;

  pid_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  pid_core u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .cfg         (cfg),
    .target      (s1_target),
    .measured    (s1_measured),
    .clear_state (s1_clear),
    .res         (res)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_target   <= target;
      s1_measured <= measured;
      s1_clear    <= clear_state;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      raw_drive <= res.raw_drive;
      drive     <= res.drive;
    end
  end

`ifndef SYNTHESIS
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && out_valid && out_stall))
    else $error("input stalled with room in the pipeline");

  a_held_item_kept: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !advance) |=> s1_valid)
    else $error("stalled transaction dropped from input register");

  a_drive_in_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ($signed(drive) <= $signed({1'b0, cfg.out_limit}) &&
                   $signed(drive) >= -$signed({1'b0, cfg.out_limit})))
    else $error("drive outside output limit");

  a_raw_saturated: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (raw_drive != $signed({1'b1, {(pid_pkg::OUT_W-1){1'b0}}})))
    else $error("raw_drive reached the most negative code");
`endif

endmodule
